[src/graph_bridge_finder_macros.svh]
// Assertion macros shared by the bridge finder RTL.
`ifndef GRAPH_BRIDGE_FINDER_MACROS_SVH
`define GRAPH_BRIDGE_FINDER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define GBF_ASSERT_IMP(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GBF_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/gbf_pkg.sv]
// Shared widths, controller states and command/status structs of the bridge finder.
`default_nettype none

package gbf_pkg;

  localparam int VERTEX_W    = 7;   // vertex numbers and vertex_count
  localparam int ROW_W       = 64;  // adjacency row payload
  localparam int TOTAL_W     = 6;   // bridge total and bridge list address
  localparam int MAX_BRIDGES = 63;  // bridge list depth

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_BASE,
    ST_EXPAND_BASE,
    ST_ROW_READ,
    ST_ROW_LATCH,
    ST_EDGE_PICK,
    ST_SCAN_TRIAL,
    ST_EXPAND_TRIAL,
    ST_FINISH,
    ST_OUT_READ,
    ST_OUT_LOAD,
    ST_OUT_WAIT
  } gbf_state_t;

  typedef struct packed {
    logic take_row;     // row transaction accepted this cycle
    logic init_run;     // clear search state for a new run
    logic pop;          // take lowest frontier vertex, read its row
    logic seed;         // open a new component at lowest unvisited vertex
    logic expand;       // merge neighbors of popped vertex
    logic masked;       // expand with the trial edge cut
    logic save_base;    // latch base component count
    logic read_row_u;   // read row of the current lower endpoint
    logic latch_edge;   // capture candidate upper endpoints
    logic pick_edge;    // choose next candidate edge, clear search state
    logic next_u;       // advance lower endpoint
    logic judge;        // compare trial count, record bridge
    logic load_empty;   // load the empty answer
    logic read_bridge;  // read bridge list entry
    logic load_bridge;  // load bridge entry into result register
    logic advance_out;  // result transaction done
  } gbf_cmd_t;

  typedef struct packed {
    logic frontier_nz;
    logic unvisited_nz;
    logic u_end;
    logic edge_nz;
    logic no_bridges;
    logic out_last;
  } gbf_status_t;

endpackage

`default_nettype wire

[src/gbf_if.sv]
// Valid/ready channel interfaces for adjacency rows and bridge results.
`default_nettype none

interface gbf_row_if;
  logic                          valid;
  logic                          ready;
  logic [gbf_pkg::VERTEX_W-1:0]  row_number;
  logic [gbf_pkg::ROW_W-1:0]     row_bits;
  logic                          last_row;

  modport source (output valid, row_number, row_bits, last_row, input ready);
  modport sink   (input valid, row_number, row_bits, last_row, output ready);
endinterface

interface gbf_result_if;
  logic                          valid;
  logic                          ready;
  logic [gbf_pkg::TOTAL_W-1:0]   bridge_total;
  logic [gbf_pkg::VERTEX_W-1:0]  lower_end;
  logic [gbf_pkg::VERTEX_W-1:0]  upper_end;
  logic                          is_bridge;
  logic                          last_result;

  modport source (output valid, bridge_total, lower_end, upper_end, is_bridge,
                  last_result, input ready);
  modport sink   (input valid, bridge_total, lower_end, upper_end, is_bridge,
                  last_result, output ready);
endinterface

`default_nettype wire

[src/gbf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gbf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/gbf_ctl.sv]
// Controller state machine: row loading, component counts, edge trials, result drain.
`default_nettype none

module gbf_ctl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_last,
  input  wire logic                 out_ready,
  input  wire gbf_pkg::gbf_status_t status,
  output logic                      in_ready,
  output logic                      out_valid,
  output gbf_pkg::gbf_cmd_t         cmd
);

  gbf_pkg::gbf_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      gbf_pkg::ST_IDLE: begin
        if (in_valid && in_last) state_next = gbf_pkg::ST_SCAN_BASE;
      end
      gbf_pkg::ST_SCAN_BASE: begin
        if (status.frontier_nz) state_next = gbf_pkg::ST_EXPAND_BASE;
        else if (!status.unvisited_nz) state_next = gbf_pkg::ST_ROW_READ;
      end
      gbf_pkg::ST_EXPAND_BASE: state_next = gbf_pkg::ST_SCAN_BASE;
      gbf_pkg::ST_ROW_READ: begin
        if (status.u_end) state_next = gbf_pkg::ST_FINISH;
        else state_next = gbf_pkg::ST_ROW_LATCH;
      end
      gbf_pkg::ST_ROW_LATCH: state_next = gbf_pkg::ST_EDGE_PICK;
      gbf_pkg::ST_EDGE_PICK: begin
        if (status.edge_nz) state_next = gbf_pkg::ST_SCAN_TRIAL;
        else state_next = gbf_pkg::ST_ROW_READ;
      end
      gbf_pkg::ST_SCAN_TRIAL: begin
        if (status.frontier_nz) state_next = gbf_pkg::ST_EXPAND_TRIAL;
        else if (!status.unvisited_nz) state_next = gbf_pkg::ST_EDGE_PICK;
      end
      gbf_pkg::ST_EXPAND_TRIAL: state_next = gbf_pkg::ST_SCAN_TRIAL;
      gbf_pkg::ST_FINISH: begin
        if (status.no_bridges) state_next = gbf_pkg::ST_OUT_WAIT;
        else state_next = gbf_pkg::ST_OUT_READ;
      end
      gbf_pkg::ST_OUT_READ: state_next = gbf_pkg::ST_OUT_LOAD;
      gbf_pkg::ST_OUT_LOAD: state_next = gbf_pkg::ST_OUT_WAIT;
      gbf_pkg::ST_OUT_WAIT: begin
        if (out_ready) begin
          if (status.out_last) state_next = gbf_pkg::ST_IDLE;
          else state_next = gbf_pkg::ST_OUT_READ;
        end
      end
      default: state_next = gbf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      gbf_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.take_row  = in_valid;
        cmd.init_run  = in_valid && in_last;
      end
      gbf_pkg::ST_SCAN_BASE: begin
        cmd.pop       = status.frontier_nz;
        cmd.seed      = !status.frontier_nz && status.unvisited_nz;
        cmd.save_base = !status.frontier_nz && !status.unvisited_nz;
      end
      gbf_pkg::ST_EXPAND_BASE: cmd.expand = 1'b1;
      gbf_pkg::ST_ROW_READ: cmd.read_row_u = !status.u_end;
      gbf_pkg::ST_ROW_LATCH: cmd.latch_edge = 1'b1;
      gbf_pkg::ST_EDGE_PICK: begin
        cmd.pick_edge = status.edge_nz;
        cmd.next_u    = !status.edge_nz;
      end
      gbf_pkg::ST_SCAN_TRIAL: begin
        cmd.pop   = status.frontier_nz;
        cmd.seed  = !status.frontier_nz && status.unvisited_nz;
        cmd.judge = !status.frontier_nz && !status.unvisited_nz;
      end
      gbf_pkg::ST_EXPAND_TRIAL: begin
        cmd.expand = 1'b1;
        cmd.masked = 1'b1;
      end
      gbf_pkg::ST_FINISH: cmd.load_empty = status.no_bridges;
      gbf_pkg::ST_OUT_READ: cmd.read_bridge = 1'b1;
      gbf_pkg::ST_OUT_LOAD: cmd.load_bridge = 1'b1;
      gbf_pkg::ST_OUT_WAIT: begin
        out_valid       = 1'b1;
        cmd.advance_out = out_ready;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

[src/gbf_dp.sv]
// Datapath: row store, visited/frontier masks, trial edge, bridge list, result register.
`default_nettype none
`include "graph_bridge_finder_macros.svh"

module gbf_dp #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [gbf_pkg::VERTEX_W-1:0]    vertex_count,
  input  wire logic [gbf_pkg::VERTEX_W-1:0]    row_number,
  input  wire logic [gbf_pkg::ROW_W-1:0]       row_bits,
  input  wire gbf_pkg::gbf_cmd_t               cmd,
  output gbf_pkg::gbf_status_t                 status,
  output logic      [gbf_pkg::TOTAL_W-1:0]     bridge_total,
  output logic      [gbf_pkg::VERTEX_W-1:0]    lower_end,
  output logic      [gbf_pkg::VERTEX_W-1:0]    upper_end,
  output logic                                 is_bridge,
  output logic                                 last_result
);

  localparam int VW  = $clog2(MAX_VERTICES);      // vertex index
  localparam int NW  = $clog2(MAX_VERTICES + 1);  // counts up to MAX_VERTICES
  localparam int PW  = 2 * VW;                    // packed bridge entry
  localparam int TW  = gbf_pkg::TOTAL_W;
  localparam int XW  = gbf_pkg::VERTEX_W;
  localparam logic [XW-1:0]           MAX_X   = XW'(MAX_VERTICES);
  localparam logic [MAX_VERTICES-1:0] ONE_BIT = MAX_VERTICES'(1);

  // index of lowest set bit; isolate it, then encode the one-hot
  function automatic logic [VW-1:0] low_index(input logic [MAX_VERTICES-1:0] x);
    logic [MAX_VERTICES-1:0] iso;
    logic [VW-1:0]           idx;
    iso = x & (~x + ONE_BIT);
    idx = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (iso[i]) idx = idx | VW'(i);
    end
    return idx;
  endfunction

  logic [XW-1:0]           vc;
  logic [MAX_VERTICES-1:0] visited, frontier, edge_row;
  logic [NW-1:0]           comps, base, u;
  logic [VW-1:0]           cu, cv, s_reg;
  logic [TW-1:0]           bcount, k;

  logic [XW-1:0]           n_x, row_off;
  logic [NW-1:0]           n;
  logic [MAX_VERTICES-1:0] live, above_u, free_bits, cut, nb, adj_rdata;
  logic [VW-1:0]           front_idx, seed_idx, edge_idx, adj_raddr;
  logic                    row_ok, adj_we, adj_re, bridge_hit;
  logic [PW-1:0]           br_rdata;

  always_comb begin
    if (vc == '0) n_x = XW'(1);
    else if (vc > MAX_X) n_x = MAX_X;
    else n_x = vc;
  end
  assign n = n_x[NW-1:0];

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      live[i]    = NW'(i) < n;
      above_u[i] = NW'(i) > u;
    end
  end

  assign free_bits = ~visited & live;
  assign front_idx = low_index(frontier);
  assign seed_idx  = low_index(free_bits);
  assign edge_idx  = low_index(edge_row);

  // during a trial both directions of the edge under test are cut
  always_comb begin
    cut = '1;
    if (cmd.masked && s_reg == cu) cut[cv] = 1'b0;
    if (cmd.masked && s_reg == cv) cut[cu] = 1'b0;
  end
  assign nb = adj_rdata & live & cut & ~visited;

  // row store
  assign row_off   = row_number - XW'(1);
  assign row_ok    = (row_number != '0) && (row_number <= MAX_X);
  assign adj_we    = cmd.take_row && row_ok;
  assign adj_re    = cmd.pop || cmd.read_row_u;
  assign adj_raddr = cmd.pop ? front_idx : u[VW-1:0];

  gbf_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (row_off[VW-1:0]),
    .wdata (row_bits[MAX_VERTICES-1:0]),
    .re    (adj_re),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  // bridge list, saturating at its depth
  assign bridge_hit = cmd.judge && (comps > base) &&
                      (bcount != TW'(gbf_pkg::MAX_BRIDGES));

  gbf_ram #(
    .WIDTH (PW),
    .DEPTH (gbf_pkg::MAX_BRIDGES)
  ) u_bridge_ram (
    .clk   (clk),
    .we    (bridge_hit),
    .waddr (bcount),
    .wdata ({cu, cv}),
    .re    (cmd.read_bridge),
    .raddr (k),
    .rdata (br_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      vc       <= XW'(MAX_VERTICES);
      visited  <= '0;
      frontier <= '0;
      comps    <= '0;
      base     <= '0;
      u        <= '0;
      bcount   <= '0;
      k        <= '0;
    end else begin
      if (cfg_write) vc <= vertex_count;
      if (cmd.init_run) begin
        visited  <= '0;
        frontier <= '0;
        comps    <= '0;
        u        <= '0;
        bcount   <= '0;
        k        <= '0;
      end
      if (cmd.pick_edge) begin
        visited  <= '0;
        frontier <= '0;
        comps    <= '0;
      end
      if (cmd.pop) frontier <= frontier & ~(ONE_BIT << front_idx);
      if (cmd.seed) begin
        visited  <= visited | (ONE_BIT << seed_idx);
        frontier <= frontier | (ONE_BIT << seed_idx);
        comps    <= comps + NW'(1);
      end
      if (cmd.expand) begin
        visited  <= visited | nb;
        frontier <= frontier | nb;
      end
      if (cmd.save_base) base <= comps;
      if (bridge_hit) bcount <= bcount + TW'(1);
      if (cmd.next_u) u <= u + NW'(1);
      if (cmd.advance_out) k <= k + TW'(1);
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.pop) s_reg <= front_idx;
    if (cmd.latch_edge) edge_row <= adj_rdata & live & above_u;
    if (cmd.pick_edge) begin
      cu       <= u[VW-1:0];
      cv       <= edge_idx;
      edge_row <= edge_row & ~(ONE_BIT << edge_idx);
    end
    if (cmd.load_empty) begin
      bridge_total <= '0;
      lower_end    <= '0;
      upper_end    <= '0;
      is_bridge    <= 1'b0;
      last_result  <= 1'b1;
    end
    if (cmd.load_bridge) begin
      bridge_total <= bcount;
      lower_end    <= XW'(br_rdata[PW-1:VW]) + XW'(1);
      upper_end    <= XW'(br_rdata[VW-1:0]) + XW'(1);
      is_bridge    <= 1'b1;
      last_result  <= ((TW + 1)'(k) + (TW + 1)'(1)) == (TW + 1)'(bcount);
    end
  end

  always_comb begin
    status.frontier_nz  = |frontier;
    status.unvisited_nz = |free_bits;
    status.u_end        = (u == n);
    status.edge_nz      = |edge_row;
    status.no_bridges   = (bcount == '0);
    status.out_last     = last_result;
  end

  // every queued vertex has already been marked
  `GBF_ASSERT_IMP(a_frontier_visited, clk, rst, 1'b1, (frontier & ~visited) == '0, "frontier vertex not visited")
  // a recorded bridge always has its endpoints in order
  `GBF_ASSERT_IMP(a_bridge_order, clk, rst, bridge_hit, cu < cv, "bridge endpoints out of order")
  // a picked edge is cleared from the pending row
  `GBF_ASSERT_NEXT(a_pick_clears, clk, rst, cmd.pick_edge, !edge_row[cv], "picked edge still pending")

endmodule

`default_nettype wire

[src/graph_bridge_finder.sv]
// Top level of the graph bridge finder: controller, datapath and channel hookup.
`default_nettype none
`include "graph_bridge_finder_macros.svh"

// Bridge finder for an undirected graph of up to MAX_VERTICES vertices. Send the
// adjacency matrix one row per transaction on the rows channel (row_number 1-based,
// bit j-1 of row_bits set for an edge to vertex j); rows load at one per cycle into
// a row RAM and persist across runs. The transaction flagged last_row starts a run:
// the block counts connected components by a frontier search, then removes each
// present edge (u,v), u<v, recounts, and records the edge as a bridge if the count
// rose. Results come out on the results channel in ascending (u,v) order, each with
// the bridge total; a graph with no bridges gives one transaction with is_bridge low.
// rows.ready is low from the last row until the final result transaction is taken.
// Sequence: a component count reads the row RAM for each reachable vertex, then
// merges its neighbors; it also seeds each component and ends with a closing step.
// Each vertex also costs a row read, a row latch and a closing edge pick, and each
// present edge one pick. Each result is read from the bridge list, loaded into the
// result register and held until taken; the empty answer is loaded in a finish
// step after the search. The row RAM has a single read port, so the search loop
// alternates a pop with its row read and an expand with its neighbor merge.
// vertex_count may only be written while the block is idle; 0 acts as 1 and values
// above MAX_VERTICES saturate. Bits and rows above vertex_count and self loops are
// ignored. At most 63 bridges are kept.

module graph_bridge_finder #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [gbf_pkg::VERTEX_W-1:0] vertex_count,
  gbf_row_if.sink                           rows,
  gbf_result_if.source                      results
);

  gbf_pkg::gbf_cmd_t    cmd;
  gbf_pkg::gbf_status_t status;

  // sequencing: load, base count, edge trials, drain
  gbf_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rows.valid),
    .in_last   (rows.last_row),
    .out_ready (results.ready),
    .status    (status),
    .in_ready  (rows.ready),
    .out_valid (results.valid),
    .cmd       (cmd)
  );

  // row store, search masks, bridge list and result register
  gbf_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .vertex_count (vertex_count),
    .row_number   (rows.row_number),
    .row_bits     (rows.row_bits),
    .cmd          (cmd),
    .status       (status),
    .bridge_total (results.bridge_total),
    .lower_end    (results.lower_end),
    .upper_end    (results.upper_end),
    .is_bridge    (results.is_bridge),
    .last_result  (results.last_result)
  );

  // a run closes the row channel on the next cycle
  `GBF_ASSERT_NEXT(a_run_blocks_rows, clk, rst, rows.valid && rows.ready && rows.last_row, !rows.ready, "rows accepted during a run")
  // result pending means no row transaction can be taken
  `GBF_ASSERT_IMP(a_sides_exclusive, clk, rst, results.valid, !rows.ready, "rows ready while result pending")
  // bridge results name their ends in order
  `GBF_ASSERT_IMP(a_result_order, clk, rst, results.valid && results.is_bridge, results.lower_end < results.upper_end, "bridge ends out of order")
  // the empty answer is a lone closing transaction with zero total
  `GBF_ASSERT_IMP(a_empty_form, clk, rst, results.valid && !results.is_bridge, results.last_result && (results.bridge_total == '0), "malformed empty answer")

endmodule

`default_nettype wire
